### rtl/elsm_pkg.sv
// Edge list sort and merge: shared types, codes and defaults.
// Used by the channel interfaces and by edge_list_sort_merge_unit.
`default_nettype none
package elsm_pkg;
    localparam int EDGE_CAPACITY_DEF = 8192;
    localparam int NODE_BITS_DEF     = 16;
    localparam int FIELD_NODE_W      = 16;
    localparam int FIELD_IDX_W       = 13;
    localparam int FIELD_CNT_W       = 14;
    localparam int MULT_W            = 14;
    localparam logic [MULT_W-1:0] MULT_MAX = '1;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_MERGE  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND2,
        ST_READ,
        ST_RUN,
        ST_SORT_RD,
        ST_SORT_WR,
        ST_DEDUP_RD,
        ST_DEDUP_WR,
        ST_DEDUP_LAST
    } t_state;
endpackage
`default_nettype wire

### rtl/elsm_if.sv
// Request and response channel interfaces for the edge list sort and merge unit.
// Depends on elsm_pkg.
`default_nettype none
interface elsm_req_if;
    import elsm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [FIELD_NODE_W-1:0] src_node;
    logic [FIELD_NODE_W-1:0] dst_node;
    logic [FIELD_IDX_W-1:0]  entry_index;
    modport source (output valid, func, src_node, dst_node, entry_index, input ready);
    modport sink   (input valid, func, src_node, dst_node, entry_index, output ready);
endinterface

interface elsm_rsp_if;
    import elsm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [FIELD_NODE_W-1:0] out_src;
    logic [FIELD_NODE_W-1:0] out_dst;
    logic [MULT_W-1:0]       multiplicity;
    logic [FIELD_CNT_W-1:0]  unique_count;
    modport source (output valid, status, out_src, out_dst, multiplicity, unique_count,
                    input ready);
    modport sink   (input valid, status, out_src, out_dst, multiplicity, unique_count,
                    output ready);
endinterface
`default_nettype wire

### rtl/edge_list_sort_merge_unit.sv
// Edge list sort and merge unit: edge store in two ping-pong memories, bottom-up merge sort
// and a folding pass. Depends on elsm_pkg and the interfaces in elsm_if.sv.
//
// Append and clear requests, failed reads, full appends and a merge of an already merged or
// nearly empty store give their response in the cycle after acceptance; a read and an append
// with symmetrize first pass through ST_READ or ST_APPEND2. A merge request walks the store
// in the memories over ceil(log2 n) merge-sort passes, each merging pairs of runs, then a folding
// pass, for n stored entries; the response is registered when the folding pass ends.
// Every request gives one response and a new request is taken once the previous response has
// been taken.
`default_nettype none
module edge_list_sort_merge_unit #(
    parameter int EDGE_CAPACITY = elsm_pkg::EDGE_CAPACITY_DEF,
    parameter int NODE_BITS     = elsm_pkg::NODE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    elsm_req_if.sink   i_req,
    elsm_rsp_if.source o_rsp
);
    import elsm_pkg::*;

    localparam int AW = $clog2(EDGE_CAPACITY);
    localparam int CW = $clog2(EDGE_CAPACITY + 1);
    localparam int EW = CW + 2;
    localparam int XW = (CW > FIELD_IDX_W) ? CW : FIELD_IDX_W;
    localparam int KW = 2 * NODE_BITS;
    localparam int DW = KW + MULT_W;

    function automatic logic [NODE_BITS-1:0] to_node(input logic [FIELD_NODE_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[NODE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_NODE_W-1:0] from_node(input logic [NODE_BITS-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[FIELD_NODE_W-1:0];
    endfunction

    function automatic logic [FIELD_CNT_W-1:0] to_cnt(input logic [CW-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[FIELD_CNT_W-1:0];
    endfunction

    logic [DW-1:0] mem0 [EDGE_CAPACITY];
    logic [DW-1:0] mem1 [EDGE_CAPACITY];
    logic [DW-1:0] r_q00, r_q01, r_q10, r_q11;

    t_state        r_state, n_state;
    logic          r_cur, n_cur;
    logic [CW-1:0] r_count, n_count;
    logic          r_merged, n_merged;
    logic          r_sym;
    logic [EW-1:0] r_w, n_w, r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [EW-1:0] r_a, n_a, r_b, n_b, r_k, n_k, r_i, n_i, r_wr, n_wr;
    logic [DW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_pend, n_pend;

    logic                    r_ovalid, n_ovalid;
    t_status                 r_ostatus, n_ostatus;
    logic [FIELD_NODE_W-1:0] r_osrc, n_osrc, r_odst, n_odst;
    logic [MULT_W-1:0]       r_omult, n_omult;
    logic [FIELD_CNT_W-1:0]  r_ocnt, n_ocnt;

    logic          we, wbank;
    logic [AW-1:0] waddr, ra0, ra1;
    logic [DW-1:0] wdata, qa, qb;

    logic [NODE_BITS-1:0] in_s, in_d;
    logic [EW-1:0]        n_ext, lo_w, lo_2w, w2;
    logic [XW-1:0]        idx_x, cnt_x;
    logic [CW:0]          need_sum;
    logic                 take_b;
    logic [MULT_W:0]      msum;

    assign qa = r_cur ? r_q10 : r_q00;
    assign qb = r_cur ? r_q11 : r_q01;

    always_ff @(posedge i_clk) begin
        if (we && !wbank) begin
            mem0[waddr] <= wdata;
        end
        r_q00 <= mem0[ra0];
        r_q01 <= mem0[ra1];
    end

    always_ff @(posedge i_clk) begin
        if (we && wbank) begin
            mem1[waddr] <= wdata;
        end
        r_q10 <= mem1[ra0];
        r_q11 <= mem1[ra1];
    end

    assign i_req.ready        = (r_state == ST_IDLE) && !r_ovalid;
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostatus;
    assign o_rsp.out_src      = r_osrc;
    assign o_rsp.out_dst      = r_odst;
    assign o_rsp.multiplicity = r_omult;
    assign o_rsp.unique_count = r_ocnt;

    assign in_s     = to_node(i_req.src_node);
    assign in_d     = to_node(i_req.dst_node);
    assign n_ext    = EW'(r_count);
    assign lo_w     = r_lo + r_w;
    assign lo_2w    = r_lo + (r_w << 1);
    assign w2       = r_w << 1;
    assign idx_x    = XW'(i_req.entry_index);
    assign cnt_x    = XW'(r_count);
    assign need_sum = {1'b0, r_count} + (r_sym ? (CW+1)'(2) : (CW+1)'(1));
    assign take_b   = (r_a >= r_mid) ||
                      ((r_b < r_hi) && (qb[DW-1:MULT_W] < qa[DW-1:MULT_W]));
    assign msum     = {1'b0, r_acc[MULT_W-1:0]} + {1'b0, qa[MULT_W-1:0]};

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_count   = r_count;
        n_merged  = r_merged;
        n_w       = r_w;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_a       = r_a;
        n_b       = r_b;
        n_k       = r_k;
        n_i       = r_i;
        n_wr      = r_wr;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_ostatus = r_ostatus;
        n_osrc    = r_osrc;
        n_odst    = r_odst;
        n_omult   = r_omult;
        n_ocnt    = r_ocnt;
        we        = 1'b0;
        wbank     = !r_cur;
        waddr     = '0;
        wdata     = '0;
        ra0       = '0;
        ra1       = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && !r_ovalid) begin
                    n_ostatus = STATUS_OK;
                    n_osrc    = '0;
                    n_odst    = '0;
                    n_omult   = '0;
                    n_ocnt    = to_cnt(r_count);
                    case (t_func'(i_req.func))
                        FUNC_APPEND: begin
                            if (need_sum > (CW+1)'(EDGE_CAPACITY)) begin
                                n_ostatus = STATUS_FULL;
                                n_ovalid  = 1'b1;
                            end else begin
                                we       = 1'b1;
                                wbank    = r_cur;
                                waddr    = r_count[AW-1:0];
                                wdata    = {in_s, in_d, MULT_W'(1)};
                                n_count  = r_count + CW'(1);
                                n_merged = 1'b0;
                                n_pend   = {in_d, in_s, MULT_W'(1)};
                                if (r_sym) begin
                                    n_state = ST_APPEND2;
                                end else begin
                                    n_ocnt   = to_cnt(n_count);
                                    n_ovalid = 1'b1;
                                end
                            end
                        end
                        FUNC_MERGE: begin
                            if (r_merged || (r_count < CW'(2))) begin
                                n_merged = 1'b1;
                                n_ovalid = 1'b1;
                            end else begin
                                n_w     = EW'(1);
                                n_lo    = '0;
                                n_state = ST_RUN;
                            end
                        end
                        FUNC_READ: begin
                            if (idx_x < cnt_x) begin
                                ra0     = idx_x[AW-1:0];
                                n_state = ST_READ;
                            end else begin
                                n_ostatus = STATUS_BAD;
                                n_ovalid  = 1'b1;
                            end
                        end
                        default: begin
                            n_count  = '0;
                            n_merged = 1'b0;
                            n_ocnt   = '0;
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            ST_APPEND2: begin
                we       = 1'b1;
                wbank    = r_cur;
                waddr    = r_count[AW-1:0];
                wdata    = r_pend;
                n_count  = r_count + CW'(1);
                n_ocnt   = to_cnt(n_count);
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_READ: begin
                n_osrc   = from_node(qa[DW-1 -: NODE_BITS]);
                n_odst   = from_node(qa[MULT_W +: NODE_BITS]);
                n_omult  = qa[MULT_W-1:0];
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_RUN: begin
                if (r_lo >= n_ext) begin
                    n_cur = !r_cur;
                    n_w   = w2;
                    n_lo  = '0;
                    if (w2 >= n_ext) begin
                        n_i     = '0;
                        n_wr    = '0;
                        n_state = ST_DEDUP_RD;
                    end
                end else begin
                    n_mid   = (lo_w < n_ext) ? lo_w : n_ext;
                    n_hi    = (lo_2w < n_ext) ? lo_2w : n_ext;
                    n_a     = r_lo;
                    n_b     = n_mid;
                    n_k     = r_lo;
                    n_state = ST_SORT_RD;
                end
            end
            ST_SORT_RD: begin
                ra0     = r_a[AW-1:0];
                ra1     = r_b[AW-1:0];
                n_state = ST_SORT_WR;
            end
            ST_SORT_WR: begin
                we    = 1'b1;
                waddr = r_k[AW-1:0];
                wdata = take_b ? qb : qa;
                if (take_b) begin
                    n_b = r_b + EW'(1);
                end else begin
                    n_a = r_a + EW'(1);
                end
                n_k = r_k + EW'(1);
                if ((r_k + EW'(1)) == r_hi) begin
                    n_lo    = r_hi;
                    n_state = ST_RUN;
                end else begin
                    n_state = ST_SORT_RD;
                end
            end
            ST_DEDUP_RD: begin
                ra0     = r_i[AW-1:0];
                n_state = ST_DEDUP_WR;
            end
            ST_DEDUP_WR: begin
                if (r_i == '0) begin
                    n_acc = qa;
                end else if (qa[DW-1:MULT_W] != r_acc[DW-1:MULT_W]) begin
                    we    = 1'b1;
                    waddr = r_wr[AW-1:0];
                    wdata = r_acc;
                    n_wr  = r_wr + EW'(1);
                    n_acc = qa;
                end else begin
                    n_acc[MULT_W-1:0] = msum[MULT_W] ? MULT_MAX : msum[MULT_W-1:0];
                end
                n_i     = r_i + EW'(1);
                n_state = ((r_i + EW'(1)) == n_ext) ? ST_DEDUP_LAST : ST_DEDUP_RD;
            end
            ST_DEDUP_LAST: begin
                we       = 1'b1;
                waddr    = r_wr[AW-1:0];
                wdata    = r_acc;
                n_count  = CW'(r_wr + EW'(1));
                n_cur    = !r_cur;
                n_merged = 1'b1;
                n_ocnt   = to_cnt(n_count);
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= 1'b0;
            r_count  <= '0;
            r_merged <= 1'b0;
            r_sym    <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_merged <= n_merged;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_sym <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_lo      <= n_lo;
        r_mid     <= n_mid;
        r_hi      <= n_hi;
        r_a       <= n_a;
        r_b       <= n_b;
        r_k       <= n_k;
        r_i       <= n_i;
        r_wr      <= n_wr;
        r_acc     <= n_acc;
        r_pend    <= n_pend;
        r_ostatus <= n_ostatus;
        r_osrc    <= n_osrc;
        r_odst    <= n_odst;
        r_omult   <= n_omult;
        r_ocnt    <= n_ocnt;
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(EDGE_CAPACITY))
        else $error("stored count beyond capacity");

    a_rsp_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == ST_IDLE))
        else $error("response pending while sequencer busy");

    a_merge_responds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_merged) |-> r_ovalid)
        else $error("merge finished without a response");

    a_fold_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEDUP_LAST) |-> (r_wr < n_ext))
        else $error("folded count exceeds stored count");
endmodule
`default_nettype wire

### sim/edge_list_sort_merge_unit_test.sv
// Testbench for edge_list_sort_merge_unit: random and directed requests, scoreboard check.
// Depends on elsm_pkg, elsm_if.sv (request/response interfaces) and the unit itself.
`timescale 1ns / 100ps
module edge_list_sort_merge_unit_test;
    import elsm_pkg::*;

    localparam int CAP = EDGE_CAPACITY_DEF;
    localparam logic [13:0] MULT_SAT = 14'd16383;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] src_node;
        logic [15:0] dst_node;
        logic [12:0] entry_index;
    } edge_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_src;
        logic [15:0] out_dst;
        logic [13:0] multiplicity;
        logic [13:0] unique_count;
    } edge_rsp_t;

    class edge_list_scoreboard;
        logic [31:0] key [CAP];
        logic [13:0] mult [CAP];
        logic [31:0] key_tmp [CAP];
        logic [13:0] mult_tmp [CAP];
        int unsigned held;
        bit merged;
        bit sym;
        edge_rsp_t pending_rsp [$];
        int errors;
        int n_req, n_rsp, n_full, n_bad, n_reads, n_merges;

        function new();
            held = 0;
            merged = 0;
            sym = 1;
            errors = 0;
            n_req = 0; n_rsp = 0; n_full = 0; n_bad = 0; n_reads = 0; n_merges = 0;
        endfunction

        function void put(logic [15:0] s, logic [15:0] d);
            key[held] = {s, d};
            mult[held] = 14'd1;
            held++;
        endfunction

        function void sort_held();
            int unsigned w, lo, mid, hi, a, b, k, i;
            for (w = 1; w < held; w = w * 2) begin
                for (lo = 0; lo < held; lo = lo + 2 * w) begin
                    mid = (lo + w < held) ? lo + w : held;
                    hi = (lo + 2 * w < held) ? lo + 2 * w : held;
                    a = lo; b = mid; k = lo;
                    while (a < mid || b < hi) begin
                        if (b < hi && (a >= mid || key[b] < key[a])) begin
                            key_tmp[k] = key[b]; mult_tmp[k] = mult[b]; b++;
                        end else begin
                            key_tmp[k] = key[a]; mult_tmp[k] = mult[a]; a++;
                        end
                        k++;
                    end
                end
                for (i = 0; i < held; i++) begin
                    key[i] = key_tmp[i];
                    mult[i] = mult_tmp[i];
                end
            end
        endfunction

        function void fold();
            int unsigned w, i;
            logic [14:0] sum;
            w = 0;
            if (merged) return;
            merged = 1;
            if (held == 0) return;
            sort_held();
            for (i = 1; i < held; i++) begin
                if (key[i] != key[w]) begin
                    w++;
                    key[w] = key[i];
                    mult[w] = mult[i];
                end else begin
                    sum = {1'b0, mult[w]} + {1'b0, mult[i]};
                    mult[w] = (sum > {1'b0, MULT_SAT}) ? MULT_SAT : sum[13:0];
                end
            end
            held = w + 1;
        endfunction

        function void note_request(edge_req_t r);
            edge_rsp_t e;
            e = '0;
            e.status = STATUS_OK;
            n_req++;
            case (r.func)
                FUNC_APPEND: begin
                    if (held + (sym ? 2 : 1) > CAP) begin
                        e.status = STATUS_FULL;
                        n_full++;
                    end else begin
                        put(r.src_node, r.dst_node);
                        if (sym) put(r.dst_node, r.src_node);
                        merged = 0;
                    end
                end
                FUNC_MERGE: begin
                    fold();
                    n_merges++;
                end
                FUNC_READ: begin
                    if (r.entry_index < held) begin
                        e.out_src = key[r.entry_index][31:16];
                        e.out_dst = key[r.entry_index][15:0];
                        e.multiplicity = mult[r.entry_index];
                        n_reads++;
                    end else begin
                        e.status = STATUS_BAD;
                        n_bad++;
                    end
                end
                default: begin
                    held = 0;
                    merged = 0;
                end
            endcase
            e.unique_count = held[13:0];
            pending_rsp.push_back(e);
        endfunction

        function void check_response(edge_rsp_t a);
            edge_rsp_t e;
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.out_src !== e.out_src) begin
                $display("%0t: out_src exp %h got %h", $time, e.out_src, a.out_src);
                errors++;
            end
            if (a.out_dst !== e.out_dst) begin
                $display("%0t: out_dst exp %h got %h", $time, e.out_dst, a.out_dst);
                errors++;
            end
            if (a.multiplicity !== e.multiplicity) begin
                $display("%0t: multiplicity exp %0d got %0d", $time, e.multiplicity,
                         a.multiplicity);
                errors++;
            end
            if (a.unique_count !== e.unique_count) begin
                $display("%0t: unique_count exp %0d got %0d", $time, e.unique_count,
                         a.unique_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   send_idle_pct;
    int   recv_idle_pct;

    elsm_req_if req_ch ();
    elsm_rsp_if rsp_ch ();

    edge_list_scoreboard sb;

    edge_list_sort_merge_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("edge_list_sort_merge_unit_test failed");
        $finish;
    end

    // response side: sample, then decide next ready
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_response({rsp_ch.status, rsp_ch.out_src, rsp_ch.out_dst,
                                   rsp_ch.multiplicity, rsp_ch.unique_count});
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(logic [1:0] f, logic [15:0] s, logic [15:0] d,
                                logic [12:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.src_node <= s;
        req_ch.dst_node <= d;
        req_ch.entry_index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request({f, s, d, idx});
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_symmetrize(bit v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.sym = v;
    endtask

    function automatic logic [15:0] pick_node();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3));
            1: return 16'($urandom_range(15));
            2: return 16'($urandom);
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic logic [12:0] pick_index();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 7) return (sb.held > 0) ? 13'($urandom_range(sb.held - 1)) : 13'd0;
        if (r == 7) return 13'(sb.held + $urandom_range(2));
        if (r == 8) return 13'($urandom);
        return 13'h1FFF;
    endfunction

    task automatic read_entry(logic [12:0] idx);
        send_request(FUNC_READ, 16'($urandom), 16'($urandom), idx);
    endtask

    task automatic random_phase(int n_items);
        int cnt, k, i;
        bit paused;
        cnt = 0;
        paused = 0;
        while (cnt < n_items) begin
            if (!paused && cnt > n_items / 2) begin
                drain();
                paused = 1;
            end
            if ($urandom_range(99) < 10) begin
                send_request(2'($urandom), 16'($urandom), 16'($urandom), 13'($urandom));
                cnt++;
            end else begin
                if (sb.held > 48 || $urandom_range(99) < 30) begin
                    send_request(FUNC_CLEAR, 16'($urandom), 16'($urandom), 13'($urandom));
                    cnt++;
                end
                k = $urandom_range(1, 12);
                for (i = 0; i < k; i++) begin
                    send_request(FUNC_APPEND, pick_node(), pick_node(), 13'($urandom));
                    cnt++;
                end
                k = $urandom_range(2);
                for (i = 0; i < k; i++) begin
                    read_entry(pick_index());
                    cnt++;
                end
                send_request(FUNC_MERGE, 16'($urandom), 16'($urandom), 13'($urandom));
                cnt++;
                if ($urandom_range(3) == 0) begin
                    send_request(FUNC_MERGE, 16'($urandom), 16'($urandom), 13'($urandom));
                    cnt++;
                end
                k = $urandom_range(1, 8);
                for (i = 0; i < k; i++) begin
                    read_entry(pick_index());
                    cnt++;
                end
            end
        end
    endtask

    initial begin
        int i;
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_APPEND;
        req_ch.src_node <= '0;
        req_ch.dst_node <= '0;
        req_ch.entry_index <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, self loops, extremes, merge twice, append after merge
        read_entry(13'd0);
        send_request(FUNC_MERGE, 16'd0, 16'd0, 13'd0);
        send_request(FUNC_APPEND, 16'h0000, 16'h0000, 13'd0);
        send_request(FUNC_APPEND, 16'hFFFF, 16'hFFFF, 13'h1FFF);
        send_request(FUNC_APPEND, 16'h0001, 16'h0002, 13'd0);
        send_request(FUNC_APPEND, 16'h0002, 16'h0001, 13'd0);
        read_entry(13'd0);
        read_entry(13'd5);
        send_request(FUNC_MERGE, 16'd0, 16'd0, 13'd0);
        send_request(FUNC_MERGE, 16'd0, 16'd0, 13'd0);
        for (i = 0; i < 5; i++) read_entry(13'(i));
        read_entry(13'h1FFF);
        send_request(FUNC_APPEND, 16'h0001, 16'h0002, 13'd0);
        read_entry(13'd4);
        send_request(FUNC_MERGE, 16'd0, 16'd0, 13'd0);
        read_entry(13'd1);
        send_request(FUNC_CLEAR, 16'd0, 16'd0, 13'd0);
        read_entry(13'd0);

        send_idle_pct = 21;
        recv_idle_pct = 69;
        random_phase(300);
        write_symmetrize(1'b1);
        random_phase(300);
        send_idle_pct = 69;
        recv_idle_pct = 21;
        write_symmetrize(1'b0);
        random_phase(250);
        write_symmetrize(1'b1);
        random_phase(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_symmetrize(1'b0);
        random_phase(300);
        write_symmetrize(1'b1);
        random_phase(300);

        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d requests, %0d responses: %0d merges, %0d good reads, %0d bad index,",
                 sb.n_req, sb.n_rsp, sb.n_merges, sb.n_reads, sb.n_bad);
        $display("%0d full appends, both symmetrize settings, %0d mismatches",
                 sb.n_full, sb.errors);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
            $display("edge_list_sort_merge_unit_test passed");
        end else begin
            $display("edge_list_sort_merge_unit_test failed");
        end
        $finish;
    end
endmodule

### sim.f
rtl/elsm_pkg.sv
rtl/elsm_if.sv
rtl/edge_list_sort_merge_unit.sv
sim/edge_list_sort_merge_unit_test.sv
